/* rtl/lfuc_pkg.sv */
// Shared types and constants for the expiring LFU cache.
package lfuc_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int FREQ_W  = 32;
  localparam int TTL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int CNT_W   = 5;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TTL      = 1'd1;

  localparam logic       REQ_GET = 1'b0;
  localparam logic       REQ_PUT = 1'b1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX        = 5'd31;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] put_value;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [CNT_W-1:0] expired_count;
  } rsp_t;

  typedef struct packed {
    logic             found;
    logic             have_min;
    logic             have_free;
    logic [CNT_W-1:0] expired;
  } scan_flags_t;

endpackage

/* rtl/lfu_cache_with_expiry.sv */
// Top level: expiring LFU cache with LRU tie-break, sequencer and result register.
//
//  channel | signals                   | direction | content
//  --------+---------------------------+-----------+--------------------------------
//  req     | req_valid req_ready req   | in        | req_type, key, put_value
//  rsp     | rsp_valid rsp_ready rsp   | out       | hit, read_value, evicted, expired_count
//  cfg     | cfg_we cfg_index cfg_data | in        | 0 capacity, 1 ttl
//
//  Each item: accept, a scan of every entry through one compare unit (one entry read
//  per cycle, registered memory read), one update write, then a load of the result
//  register. No new item is taken until the block is back in idle. Synchronous reset
//  clears all valid bits, the step counter and the control flops, and sets capacity
//  to 16 and ttl to all ones. A result held by rsp_ready low stalls the block in S_FIN.
module lfu_cache_with_expiry import lfuc_pkg::*; #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int LW = (UW > CAP_W) ? UW : CAP_W;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]           state;
  logic [IW-1:0]        cnt;
  logic                 issued;
  logic                 live;
  logic [IW-1:0]        scan_idx;
  logic [TIME_BITS-1:0] step;
  logic [CAP_W-1:0]     capacity;
  logic [TTL_W-1:0]     ttl;
  req_t                 cur;
  rsp_t                 res;

  logic [KEY_W-1:0]     rd_key;
  logic [VAL_W-1:0]     rd_value;
  logic [FREQ_W-1:0]    rd_freq;
  logic [TIME_BITS-1:0] rd_stamp;
  logic [ENTRIES-1:0]   vld;

  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [VAL_W-1:0]     wr_value;
  logic [FREQ_W-1:0]    wr_freq;
  logic                 vld_clr;
  logic [IW-1:0]        vld_clr_idx;
  logic                 vld_set;

  logic                 expire;
  scan_flags_t          flags;
  logic [UW-1:0]        used;
  logic [IW-1:0]        found_idx;
  logic [FREQ_W-1:0]    found_freq;
  logic [VAL_W-1:0]     found_value;
  logic [IW-1:0]        min_idx;
  logic [IW-1:0]        free_idx;

  logic [LW-1:0]        limit;
  logic                 is_put;
  logic                 do_evict;
  logic                 accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign is_put    = (cur.req_type == REQ_PUT);

  always_comb begin
    if (capacity == '0) begin
      limit = LW'(1);
    end else if (LW'(capacity) > LW'(ENTRIES)) begin
      limit = LW'(ENTRIES);
    end else begin
      limit = LW'(capacity);
    end
    do_evict = is_put && !flags.found && flags.have_min && (LW'(used) >= limit);

    wr_en       = 1'b0;
    wr_addr     = found_idx;
    wr_value    = is_put ? cur.put_value : found_value;
    wr_freq     = (found_freq == '1) ? found_freq : found_freq + 1'b1;
    vld_clr     = expire;
    vld_clr_idx = scan_idx;
    vld_set     = 1'b0;
    if (state == S_UPD) begin
      if (flags.found) begin
        wr_en = 1'b1;
      end else if (is_put) begin
        wr_en   = 1'b1;
        vld_set = 1'b1;
        wr_freq = FREQ_W'(1);
        wr_addr = (do_evict && (!flags.have_free || min_idx < free_idx)) ? min_idx : free_idx;
        if (do_evict) begin
          vld_clr     = 1'b1;
          vld_clr_idx = min_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      issued    <= 1'b0;
      live      <= 1'b0;
      step      <= '0;
      capacity  <= CAPACITY_RESET;
      ttl       <= '1;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CAPACITY: capacity <= cfg_data[CAP_W-1:0];
          REG_TTL:      ttl      <= cfg_data[TTL_W-1:0];
          default: ;
        endcase
      end
      if (state == S_FIN && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      live <= (state == S_SCAN) && !issued;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur    <= req;
            cnt    <= '0;
            issued <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!issued) begin
            scan_idx <= cnt;
            cnt      <= cnt + 1'b1;
            if (cnt == LAST) issued <= 1'b1;
          end
          if (live && scan_idx == LAST) state <= S_UPD;
        end
        S_UPD: begin
          step              <= step + 1'b1;
          res.hit           <= !is_put && flags.found;
          res.read_value    <= (!is_put && flags.found) ? found_value : '0;
          res.evicted       <= do_evict;
          res.expired_count <= flags.expired;
          state             <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lfuc_store #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .rd_addr     (cnt),
    .rd_key      (rd_key),
    .rd_value    (rd_value),
    .rd_freq     (rd_freq),
    .rd_stamp    (rd_stamp),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_key      (cur.key),
    .wr_value    (wr_value),
    .wr_freq     (wr_freq),
    .wr_stamp    (step),
    .vld_clr     (vld_clr),
    .vld_clr_idx (vld_clr_idx),
    .vld_set     (vld_set),
    .vld_set_idx (wr_addr),
    .vld         (vld)
  );

  lfuc_scan #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .live        (live),
    .idx         (scan_idx),
    .e_valid     (vld[scan_idx]),
    .e_key       (rd_key),
    .e_value     (rd_value),
    .e_freq      (rd_freq),
    .e_stamp     (rd_stamp),
    .now         (step),
    .ttl         (ttl),
    .req_key     (cur.key),
    .expire      (expire),
    .flags       (flags),
    .used        (used),
    .found_idx   (found_idx),
    .found_freq  (found_freq),
    .found_value (found_value),
    .min_idx     (min_idx),
    .free_idx    (free_idx)
  );

endmodule

/* rtl/lfuc_store.sv */
// Entry storage: key/value/frequency/stamp memories and valid flops.
module lfuc_store import lfuc_pkg::*; #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 32,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IW-1:0]        rd_addr,
  output logic [KEY_W-1:0]     rd_key,
  output logic [VAL_W-1:0]     rd_value,
  output logic [FREQ_W-1:0]    rd_freq,
  output logic [TIME_BITS-1:0] rd_stamp,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_addr,
  input  logic [KEY_W-1:0]     wr_key,
  input  logic [VAL_W-1:0]     wr_value,
  input  logic [FREQ_W-1:0]    wr_freq,
  input  logic [TIME_BITS-1:0] wr_stamp,
  input  logic                 vld_clr,
  input  logic [IW-1:0]        vld_clr_idx,
  input  logic                 vld_set,
  input  logic [IW-1:0]        vld_set_idx,
  output logic [ENTRIES-1:0]   vld
);

  logic [KEY_W-1:0]     key_mem   [ENTRIES];
  logic [VAL_W-1:0]     value_mem [ENTRIES];
  logic [FREQ_W-1:0]    freq_mem  [ENTRIES];
  logic [TIME_BITS-1:0] stamp_mem [ENTRIES];
  logic [ENTRIES-1:0]   vld_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
      freq_mem[wr_addr]  <= wr_freq;
      stamp_mem[wr_addr] <= wr_stamp;
    end
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
    rd_freq  <= freq_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
  end

  // set wins over clear on the same entry
  always_comb begin
    vld_next = vld;
    if (vld_clr) vld_next[vld_clr_idx] = 1'b0;
    if (vld_set) vld_next[vld_set_idx] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

endmodule

/* rtl/lfuc_scan.sv */
// Per-entry compare unit: expiry, key match, LFU/LRU minimum and free slot.
module lfuc_scan import lfuc_pkg::*; #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 32,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int UW = $clog2(ENTRIES + 1),
  localparam int CW = (TIME_BITS > TTL_W) ? TIME_BITS : TTL_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 live,
  input  logic [IW-1:0]        idx,
  input  logic                 e_valid,
  input  logic [KEY_W-1:0]     e_key,
  input  logic [VAL_W-1:0]     e_value,
  input  logic [FREQ_W-1:0]    e_freq,
  input  logic [TIME_BITS-1:0] e_stamp,
  input  logic [TIME_BITS-1:0] now,
  input  logic [TTL_W-1:0]     ttl,
  input  logic [KEY_W-1:0]     req_key,
  output logic                 expire,
  output scan_flags_t          flags,
  output logic [UW-1:0]        used,
  output logic [IW-1:0]        found_idx,
  output logic [FREQ_W-1:0]    found_freq,
  output logic [VAL_W-1:0]     found_value,
  output logic [IW-1:0]        min_idx,
  output logic [IW-1:0]        free_idx
);

  logic [TIME_BITS-1:0] age;
  logic                 alive;
  logic                 less;
  logic [FREQ_W-1:0]    min_freq;
  logic [TIME_BITS-1:0] min_stamp;

  always_comb begin
    age    = now - e_stamp;
    expire = live && e_valid && (CW'(age) > CW'(ttl));
    alive  = e_valid && !expire;
    less   = !flags.have_min || (e_freq < min_freq) ||
             ((e_freq == min_freq) && (e_stamp < min_stamp));
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
      used  <= '0;
    end else if (live) begin
      if (expire && flags.expired != CNT_MAX) flags.expired <= flags.expired + 1'b1;
      if (alive) begin
        used <= used + 1'b1;
        if (!flags.found && e_key == req_key) begin
          flags.found <= 1'b1;
          found_idx   <= idx;
          found_freq  <= e_freq;
          found_value <= e_value;
        end
        if (less) begin
          flags.have_min <= 1'b1;
          min_idx        <= idx;
          min_freq       <= e_freq;
          min_stamp      <= e_stamp;
        end
      end else if (!flags.have_free) begin
        flags.have_free <= 1'b1;
        free_idx        <= idx;
      end
    end
  end

endmodule

/* tb/tb_lfu_cache_with_expiry.sv */
`timescale 1ns / 100ps
// Testbench for lfu_cache_with_expiry: directed table, then random traffic checked by a cache predictor.
module tb_lfu_cache_with_expiry;
  import lfuc_pkg::*;

  localparam int ENTRIES    = 16;
  localparam int WAIT_LIMIT = 4000;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    req_t                 rq;
    logic                 typed;
    rsp_t                 want;
  } plan_row_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_t                 req       = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // predictor state
  logic             slot_live [ENTRIES];
  logic [KEY_W-1:0] slot_key [ENTRIES];
  logic [VAL_W-1:0] slot_val [ENTRIES];
  logic [FREQ_W-1:0] slot_freq [ENTRIES];
  logic [31:0]      slot_stamp [ENTRIES];
  logic [31:0]      now_step;
  logic [CAP_W-1:0] cap_reg;
  logic [TTL_W-1:0] ttl_reg;

  rsp_t      exp_q[$];
  plan_row_t plan[$];
  int gap_pct   = 12;
  int stall_pct = 79;
  int errors    = 0;
  int idle_run  = 0;
  int n_sent = 0, n_hit = 0, n_evict = 0, n_expired = 0, n_writes = 0;

  lfu_cache_with_expiry #(.ENTRIES(ENTRIES), .TIME_BITS(32)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic rsp_t cache_step(input req_t r);
    rsp_t o;
    int found, victim, used, lim;
    logic placed;
    o = '0;
    found = -1;
    victim = -1;
    used = 0;
    placed = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && (now_step - slot_stamp[i]) > ttl_reg) begin
        slot_live[i] = 1'b0;
        if (o.expired_count != CNT_MAX) o.expired_count++;
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i]) begin
        used++;
        if (found < 0 && slot_key[i] == r.key) found = i;
      end
    end
    if (found >= 0) begin
      if (r.req_type == REQ_GET) begin
        o.hit = 1'b1;
        o.read_value = slot_val[found];
      end else begin
        slot_val[found] = r.put_value;
      end
      if (slot_freq[found] != '1) slot_freq[found]++;
      slot_stamp[found] = now_step;
    end else if (r.req_type == REQ_PUT) begin
      lim = (cap_reg == 0) ? 1 : int'(cap_reg);
      if (lim > ENTRIES) lim = ENTRIES;
      if (used >= lim) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_live[i] && (victim < 0 || slot_freq[i] < slot_freq[victim] ||
              (slot_freq[i] == slot_freq[victim] && slot_stamp[i] < slot_stamp[victim])))
            victim = i;
        end
        if (victim >= 0) begin
          slot_live[victim] = 1'b0;
          o.evicted = 1'b1;
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (!placed && !slot_live[i]) begin
          placed = 1'b1;
          slot_live[i] = 1'b1;
          slot_key[i] = r.key;
          slot_val[i] = r.put_value;
          slot_freq[i] = 1;
          slot_stamp[i] = now_step;
        end
      end
    end
    now_step++;
    return o;
  endfunction

  function automatic plan_row_t ask(input logic t, input logic [KEY_W-1:0] k,
                                    input logic [VAL_W-1:0] v);
    plan_row_t row;
    row = '0;
    row.rq.req_type = t;
    row.rq.key = k;
    row.rq.put_value = v;
    return row;
  endfunction

  function automatic plan_row_t check(input logic t, input logic [KEY_W-1:0] k,
                                      input logic [VAL_W-1:0] v, input logic h,
                                      input logic [VAL_W-1:0] rd, input logic ev,
                                      input logic [CNT_W-1:0] ex);
    plan_row_t row;
    row = ask(t, k, v);
    row.typed = 1'b1;
    row.want.hit = h;
    row.want.read_value = rd;
    row.want.evicted = ev;
    row.want.expired_count = ex;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  task automatic add_row(input plan_row_t row);
    plan.insert(plan.size(), row);
  endtask

  task automatic send_item(input req_t r, input logic typed, input rsp_t want);
    rsp_t model;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    model = cache_step(r);
    exp_q.insert(exp_q.size(), typed ? want : model);
    n_sent++;
  endtask

  // hold off until every result is back and the block is idle
  task automatic settle();
    req_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPACITY) cap_reg = data[CAP_W-1:0];
    else ttl_reg = data[TTL_W-1:0];
    n_writes++;
    @(posedge clk);
  endtask

  task automatic random_burst(input int count);
    logic [KEY_W-1:0] pool [24];
    int pool_n;
    req_t r;
    pool_n = $urandom_range(24, 2);
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = '0;
    pool[1] = '1;
    repeat (count) begin
      r.req_type = 1'($urandom_range(1));
      r.key = ($urandom_range(99) < 85) ? pool[$urandom_range(pool_n - 1)] : $urandom;
      r.put_value = $urandom;
      send_item(r, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_t want;
      if (exp_q.size() == 0) begin
        $error("response item with no request pending");
        errors++;
      end else begin
        want = exp_q[0];
        exp_q.delete(0);
        if (rsp.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
          errors++;
        end
        if (rsp.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
          errors++;
        end
        if (rsp.evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, rsp.evicted);
          errors++;
        end
        if (rsp.expired_count !== want.expired_count) begin
          $error("expired_count: expected %0d, got %0d", want.expired_count,
                 rsp.expired_count);
          errors++;
        end
        n_hit += want.hit;
        n_evict += want.evicted;
        n_expired += want.expired_count;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run == WAIT_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0] cap_pick;
    logic [TTL_W-1:0] ttl_pick;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    now_step = '0;
    cap_reg = CAPACITY_RESET;
    ttl_reg = '1;

    add_row(check(REQ_GET, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 5'd0));
    add_row(check(REQ_PUT, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 5'd0));
    add_row(check(REQ_GET, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0, 5'd0));
    add_row(check(REQ_PUT, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0, 5'd0));
    add_row(check(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 5'd0));
    add_row(ask(REQ_PUT, 32'h0, 32'h1234_5678));
    add_row(check(REQ_GET, 32'h0, 32'h0, 1'b1, 32'h1234_5678, 1'b0, 5'd0));
    add_row(reg_row(REG_CAPACITY, 32'd2));
    add_row(check(REQ_PUT, 32'hA5A5_A5A5, 32'h1, 1'b0, 32'h0, 1'b1, 5'd0));
    add_row(check(REQ_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0, 5'd0));
    add_row(reg_row(REG_CAPACITY, 32'd0));
    add_row(check(REQ_PUT, 32'h5A5A_5A5A, 32'h2, 1'b0, 32'h0, 1'b1, 5'd0));
    add_row(reg_row(REG_CAPACITY, 32'd31));
    add_row(reg_row(REG_TTL, 32'd0));
    add_row(check(REQ_GET, 32'h5A5A_5A5A, 32'hDEAD_BEEF, 1'b0, 32'h0, 1'b0, 5'd2));
    add_row(check(REQ_PUT, 32'h1, 32'h2, 1'b0, 32'h0, 1'b0, 5'd0));
    add_row(check(REQ_GET, 32'h1, 32'h0, 1'b0, 32'h0, 1'b0, 5'd1));
    add_row(ask(REQ_PUT, 32'h1, 32'h3));
    add_row(reg_row(REG_TTL, 32'd1));
    add_row(check(REQ_GET, 32'h1, 32'h0, 1'b1, 32'h3, 1'b0, 5'd0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        settle();
        write_reg(plan[n].idx, plan[n].data);
      end else begin
        send_item(plan[n].rq, plan[n].typed, plan[n].want);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      gap_pct   = (mode == 0) ? 12 : (mode == 1) ? 79 : 0;
      stall_pct = (mode == 0) ? 79 : (mode == 1) ? 12 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        case (seg)
          0: begin
            cap_pick = CAP_W'(ENTRIES);
            ttl_pick = '1;
          end
          1: begin
            cap_pick = 5'd1;
            ttl_pick = $urandom_range(8, 1);
          end
          2: begin
            cap_pick = 5'd0;
            ttl_pick = '0;
          end
          3: begin
            cap_pick = 5'd31;
            ttl_pick = $urandom_range(200, 20);
          end
          4: begin
            cap_pick = CAP_W'($urandom_range(ENTRIES, 1));
            ttl_pick = $urandom_range(30, 2);
          end
          default: begin
            cap_pick = CAP_W'($urandom_range(ENTRIES - 1, 2));
            ttl_pick = $urandom;
          end
        endcase
        settle();
        write_reg(REG_CAPACITY, CFG_W'(cap_pick));
        write_reg(REG_TTL, ttl_pick);
        random_burst(55);
      end
    end

    settle();
    repeat (2 * (ENTRIES + 4)) @(posedge clk);
    $display("Checked %0d requests under %0d register writes across three idle patterns.",
             n_sent, n_writes);
    $display("Seen: %0d get hits, %0d evictions, %0d expired entries.",
             n_hit, n_evict, n_expired);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
